// ===== hw/rtl/kvt_pkg.sv =====
`timescale 1ns / 1ps

package kvt_pkg;

    localparam int DATA_W  = 32;
    localparam int COUNT_W = 6;

    localparam logic [1:0] KVT_OP_ADD    = 2'd0;
    localparam logic [1:0] KVT_OP_SEARCH = 2'd1;
    localparam logic [1:0] KVT_OP_REMOVE = 2'd2;

    localparam logic [2:0] KVT_ST_INSERTED  = 3'd0;
    localparam logic [2:0] KVT_ST_UPDATED   = 3'd1;
    localparam logic [2:0] KVT_ST_FOUND     = 3'd2;
    localparam logic [2:0] KVT_ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] KVT_ST_REMOVED   = 3'd4;
    localparam logic [2:0] KVT_ST_FULL      = 3'd5;

    typedef struct packed {
        logic [1:0]               operation;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] value;
    } kvt_req_t;

    typedef struct packed {
        logic [2:0]               status;
        logic signed [DATA_W-1:0] value_out;
        logic [COUNT_W-1:0]       entry_count;
    } kvt_rsp_t;

    typedef struct packed {
        logic capture;
        logic update;
        logic append;
        logic remove;
    } kvt_ctrl_t;

    typedef enum logic {
        KVT_IDLE,
        KVT_APPLY
    } kvt_state_t;

endpackage

// ===== hw/rtl/key_value_table.sv =====
`timescale 1ns / 1ps

// channel   dir  beat       handshake
// req       in   kvt_req_t  req_valid / req_stall
// rsp       out  kvt_rsp_t  rsp_valid / rsp_stall
//
// per request, the accept edge compares every cell key at once,
// then the apply state performs the add, update or shifting remove in the cell row
// a result waits in the output register while the next request is accepted
// rsp_stall holds the apply cycle only while the output register is occupied
// reset empties the table at once through the entry count

module key_value_table #(
    parameter int CAPACITY = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  kvt_pkg::kvt_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output kvt_pkg::kvt_rsp_t rsp
);
    import kvt_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    kvt_state_t state_reg;
    kvt_state_t state_next;

    kvt_req_t           req_reg;
    kvt_rsp_t           rsp_reg;
    kvt_rsp_t           rsp_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    logic               accept;
    logic               apply_go;
    kvt_ctrl_t          ctrl;

    logic signed [DATA_W-1:0] cell_key   [CAPACITY];
    logic signed [DATA_W-1:0] cell_value [CAPACITY];
    logic signed [DATA_W-1:0] cell_sel   [CAPACITY];
    logic [CAPACITY-1:0]      cell_hit;
    logic [CAPACITY-1:0]      cell_shift;

    logic signed [DATA_W-1:0] found_value;
    logic                     any_hit;
    logic                     full;

    // state machine outputs
    always_comb
    begin
        req_stall = 1'b1;
        apply_go  = 1'b0;
        case (state_reg)
            KVT_IDLE:
            begin
                req_stall = 1'b0;
            end
            KVT_APPLY:
            begin
                apply_go = !rsp_valid_reg || !rsp_stall;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    assign accept = req_valid && !req_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            KVT_IDLE:
            begin
                if (accept)
                begin
                    state_next = KVT_APPLY;
                end
            end
            KVT_APPLY:
            begin
                if (apply_go)
                begin
                    state_next = KVT_IDLE;
                end
            end
            default:
            begin
                state_next = KVT_IDLE;
            end
        endcase
    end

    assign any_hit = |cell_hit;
    assign full    = count_reg == CAP_C;

    always_comb
    begin
        found_value = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            found_value = found_value | cell_sel[i];
        end
    end

    always_comb
    begin
        ctrl.capture = accept;
        ctrl.update  = apply_go && (req_reg.operation == KVT_OP_ADD) && any_hit;
        ctrl.append  = apply_go && (req_reg.operation == KVT_OP_ADD) && !any_hit && !full;
        ctrl.remove  = apply_go && (req_reg.operation == KVT_OP_REMOVE) && any_hit;
    end

    // cell row, shift chain runs from low to high slots
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic signed [DATA_W-1:0] nb_key;
        logic signed [DATA_W-1:0] nb_value;
        logic                     sh_in;

        if (g == CAPACITY - 1)
        begin : g_last
            assign nb_key   = '0;
            assign nb_value = '0;
        end
        else
        begin : g_mid
            assign nb_key   = cell_key[g+1];
            assign nb_value = cell_value[g+1];
        end

        if (g == 0)
        begin : g_first
            assign sh_in = 1'b0;
        end
        else
        begin : g_rest
            assign sh_in = cell_shift[g-1];
        end

        kvt_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .count      (count_reg),
            .req_key    (req.key),
            .new_key    (req_reg.key),
            .new_value  (req_reg.value),
            .next_key   (nb_key),
            .next_value (nb_value),
            .shift_in   (sh_in),
            .key        (cell_key[g]),
            .value      (cell_value[g]),
            .hit        (cell_hit[g]),
            .shift_out  (cell_shift[g]),
            .hit_value  (cell_sel[g])
        );
    end

    always_comb
    begin
        count_next         = count_reg;
        rsp_next           = rsp_reg;
        rsp_valid_next     = rsp_valid_reg && rsp_stall;
        if (apply_go)
        begin
            rsp_valid_next     = 1'b1;
            rsp_next.status    = KVT_ST_NOT_FOUND;
            rsp_next.value_out = '0;
            case (req_reg.operation)
                KVT_OP_ADD:
                begin
                    if (any_hit)
                    begin
                        rsp_next.status    = KVT_ST_UPDATED;
                        rsp_next.value_out = found_value;
                    end
                    else if (!full)
                    begin
                        rsp_next.status = KVT_ST_INSERTED;
                        count_next      = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        rsp_next.status = KVT_ST_FULL;
                    end
                end
                KVT_OP_SEARCH:
                begin
                    if (any_hit)
                    begin
                        rsp_next.status    = KVT_ST_FOUND;
                        rsp_next.value_out = found_value;
                    end
                end
                KVT_OP_REMOVE:
                begin
                    if (any_hit)
                    begin
                        rsp_next.status    = KVT_ST_REMOVED;
                        rsp_next.value_out = found_value;
                        count_next         = count_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    rsp_next.status = KVT_ST_NOT_FOUND;
                end
            endcase
            rsp_next.entry_count = COUNT_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= KVT_IDLE;
            rsp_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // keys are unique, so at most one cell matches
    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cell_hit))
        else $error("more than one cell matched the key");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("entry count above capacity");

    a_count_moves_on_apply: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> $past(state_reg == KVT_APPLY))
        else $error("entry count changed outside the apply cycle");

    a_rsp_from_apply: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == KVT_APPLY))
        else $error("result raised without an apply cycle");

endmodule

// ===== hw/rtl/kvt_cell.sv =====
`timescale 1ns / 1ps

module kvt_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 6
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  kvt_pkg::kvt_ctrl_t                ctrl,
    input  logic [CNT_W-1:0]                  count,
    input  logic signed [kvt_pkg::DATA_W-1:0] req_key,
    input  logic signed [kvt_pkg::DATA_W-1:0] new_key,
    input  logic signed [kvt_pkg::DATA_W-1:0] new_value,
    input  logic signed [kvt_pkg::DATA_W-1:0] next_key,
    input  logic signed [kvt_pkg::DATA_W-1:0] next_value,
    input  logic                              shift_in,
    output logic signed [kvt_pkg::DATA_W-1:0] key,
    output logic signed [kvt_pkg::DATA_W-1:0] value,
    output logic                              hit,
    output logic                              shift_out,
    output logic signed [kvt_pkg::DATA_W-1:0] hit_value
);
    import kvt_pkg::*;

    localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

    logic signed [DATA_W-1:0] key_reg;
    logic signed [DATA_W-1:0] key_next;
    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;
    logic                     hit_reg;
    logic                     hit_next;
    logic                     occupied;

    assign occupied  = IDX_C < count;
    assign shift_out = hit_reg | shift_in;
    assign key       = key_reg;
    assign value     = value_reg;
    assign hit       = hit_reg;
    assign hit_value = hit_reg ? value_reg : '0;

    always_comb
    begin
        hit_next = hit_reg;
        if (ctrl.capture)
        begin
            hit_next = occupied && (key_reg == req_key);
        end
    end

    always_comb
    begin
        key_next   = key_reg;
        value_next = value_reg;
        if (ctrl.remove && shift_out)
        begin
            key_next   = next_key;
            value_next = next_value;
        end
        else if (ctrl.append && (IDX_C == count))
        begin
            key_next   = new_key;
            value_next = new_value;
        end
        else if (ctrl.update && hit_reg)
        begin
            value_next = new_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

endmodule
